/* src/ebb_pkg.sv */
package ebb_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DIM_W          = 13;
  localparam int COORD_W        = 8;
  localparam int PIX_W          = 32;
  localparam int ACC_W          = 12;
  localparam int ALPHA_W        = 5;
  localparam int NUM_CH         = 4;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] REG_RADIUS     = 3'd0;
  localparam logic [2:0] REG_ALPHA_ONLY = 3'd1;
  localparam logic [2:0] REG_TOP        = 3'd2;
  localparam logic [2:0] REG_BOTTOM     = 3'd3;
  localparam logic [2:0] REG_LEFT       = 3'd4;
  localparam logic [2:0] REG_RIGHT      = 3'd5;

  localparam logic [ALPHA_W-1:0] RADIUS_ALPHA [17] = '{
    5'd14, 5'd10, 5'd8, 5'd6, 5'd5, 5'd5, 5'd4, 5'd3, 5'd3,
    5'd3,  5'd3,  5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2
  };

  typedef struct packed {
    logic                seed;
    logic                update;
    logic                alpha_only;
    logic [ALPHA_W-1:0]  alpha;
  } filt_ctrl_t;

  typedef struct packed {
    logic [COORD_W-1:0] line_first;
    logic [COORD_W-1:0] line_last;
    logic [COORD_W-1:0] along_first;
    logic [COORD_W-1:0] along_last;
  } span_t;

  function automatic logic [ALPHA_W-1:0] alpha_of_radius(input logic [4:0] r);
    logic [4:0] idx;
    idx = r - 5'd1;
    if (r == 5'd0) begin
      return 5'd16;
    end else if (r > 5'd17) begin
      return 5'd1;
    end else begin
      return RADIUS_ALPHA[idx];
    end
  endfunction

endpackage

/* src/ebb_ram.sv */
module ebb_ram
  import ebb_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/ebb_filter.sv */
module ebb_filter
  import ebb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  filt_ctrl_t       ctrl,
  input  logic [PIX_W-1:0] word_in,
  output logic [PIX_W-1:0] word_out
);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [ACC_W-1:0]  acc_r;
    logic [ACC_W-1:0]  acc_nxt;
    logic [7:0]        byte_in;
    logic [ACC_W-1:0]  pix16;
    logic signed [13:0] diff;
    logic signed [19:0] prod;
    logic signed [19:0] bias;
    logic signed [19:0] quo;
    logic              active;

    assign byte_in = word_in[8*c +: 8];
    assign pix16   = {byte_in, 4'h0};
    assign active  = !ctrl.alpha_only || (c == NUM_CH - 1);
    assign diff    = $signed({2'b00, pix16}) - $signed({2'b00, acc_r});
    assign prod    = diff * $signed({1'b0, ctrl.alpha});
    // divide by 16 rounding toward zero
    assign bias    = prod + (prod[19] ? 20'sd15 : 20'sd0);
    assign quo     = bias >>> 4;
    assign acc_nxt = acc_r + quo[ACC_W-1:0];

    assign word_out[8*c +: 8] = active ? acc_nxt[ACC_W-1:4] : byte_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r <= '0;
      end else if (active && ctrl.seed) begin
        acc_r <= pix16;
      end else if (active && ctrl.update) begin
        acc_r <= acc_nxt;
      end
    end
  end

endmodule

/* src/exponential_box_blur.sv */
// Exponential blur engine over an internal frame store of premultiplied ARGB pixels.
// Input channel: in_valid/in_stall with in_opcode, in_pos_x, in_pos_y, in_pixel_in.
//   Write stores in_pixel_in, read fetches a pixel, run blurs the configured rectangle
//   in place with four recursive passes (down, right, up, left).
// Result channel: out_valid/out_stall with out_pixel_out and out_op_done; exactly one
//   result per request, in request order, held in an output register.
// Config port: cfg_we, cfg_index, cfg_data; the user must write it only while the
//   block is idle, which the block itself does not enforce.
// Write, rejected requests and an empty rectangle answer at once; a read first passes
//   through one memory read (S_READ). A run reads, then filters and writes back each
//   pixel of each pass (the first of a line only seeds the filter), after a setup state
//   per pass, then reports; its pace is set by the frame memory's read-modify-write.
// One request at a time: in_stall is high while a request is in progress, and also
//   while the output register holds a result that out_stall keeps from leaving.
// Reset (synchronous, rst_n low) clears control state, the accumulators and the config
//   registers; the frame store is not cleared and reads as undefined until written.
module exponential_box_blur
  import ebb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [COORD_W-1:0] in_pos_x,
  input  logic [COORD_W-1:0] in_pos_y,
  input  logic [PIX_W-1:0]   in_pixel_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   out_pixel_out,
  output logic               out_op_done
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] X_LAST = DIM_W'(MAX_WIDTH - 1);
  localparam logic [DIM_W-1:0] Y_LAST = DIM_W'(MAX_HEIGHT - 1);
  localparam logic [1:0] PASS_DOWN  = 2'd0;
  localparam logic [1:0] PASS_RIGHT = 2'd1;
  localparam logic [1:0] PASS_UP    = 2'd2;
  localparam logic [1:0] PASS_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_PASS, S_SEED_RD, S_SEED, S_PIX_RD, S_PIX_WR, S_DONE
  } state_t;

  state_t state_r;

  logic [4:0]         blur_radius_r;
  logic               alpha_only_r;
  logic [COORD_W-1:0] rect_top_r;
  logic [COORD_W-1:0] rect_bottom_r;
  logic [COORD_W-1:0] rect_left_r;
  logic [COORD_W-1:0] rect_right_r;

  logic [1:0]         pass_r;
  logic [COORD_W-1:0] line_r;
  logic [COORD_W-1:0] along_r;
  logic [COORD_W-1:0] bot_r;
  logic [COORD_W-1:0] right_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   pixel_out_r;
  logic               op_done_r;

  logic               accept;
  logic               on_frame;
  logic               result_load;
  logic [AW-1:0]      in_addr;
  logic [COORD_W-1:0] seq_x;
  logic [COORD_W-1:0] seq_y;
  logic [AW-1:0]      seq_addr;
  logic [COORD_W-1:0] bot_clip;
  logic [COORD_W-1:0] right_clip;
  logic               rect_empty;
  span_t              span;
  logic               line_end;
  logic [COORD_W-1:0] along_step;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [PIX_W-1:0]   ram_wdata;
  logic [PIX_W-1:0]   ram_rdata;
  filt_ctrl_t         filt_ctrl;
  logic [PIX_W-1:0]   filt_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blur_radius_r <= '0;
      alpha_only_r  <= 1'b0;
      rect_top_r    <= '0;
      rect_bottom_r <= 8'd255;
      rect_left_r   <= '0;
      rect_right_r  <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:     blur_radius_r <= cfg_data[4:0];
        REG_ALPHA_ONLY: alpha_only_r  <= cfg_data[0];
        REG_TOP:        rect_top_r    <= cfg_data;
        REG_BOTTOM:     rect_bottom_r <= cfg_data;
        REG_LEFT:       rect_left_r   <= cfg_data;
        REG_RIGHT:      rect_right_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign on_frame = (DIM_W'(in_pos_x) < DIM_W'(MAX_WIDTH)) &&
                    (DIM_W'(in_pos_y) < DIM_W'(MAX_HEIGHT));
  assign in_addr  = AW'(in_pos_y) * AW'(MAX_WIDTH) + AW'(in_pos_x);

  assign bot_clip   = (DIM_W'(rect_bottom_r) > Y_LAST) ? Y_LAST[COORD_W-1:0] : rect_bottom_r;
  assign right_clip = (DIM_W'(rect_right_r) > X_LAST) ? X_LAST[COORD_W-1:0] : rect_right_r;
  assign rect_empty = (rect_top_r > bot_clip) || (rect_left_r > right_clip);

  // a request answered at once, or a read or run reaching its end
  assign result_load = (accept && !((in_opcode == OP_READ) && on_frame) &&
                        !((in_opcode == OP_RUN) && !rect_empty)) ||
                       (state_r == S_READ) || (state_r == S_DONE);

  always_comb begin
    unique case (pass_r)
      PASS_DOWN: span = '{rect_left_r, right_r, rect_top_r, bot_r};
      PASS_RIGHT: span = '{rect_top_r, bot_r, rect_left_r, right_r};
      PASS_UP: span = '{rect_left_r, right_r, bot_r, rect_top_r};
      PASS_LEFT: span = '{rect_top_r, bot_r, right_r, rect_left_r};
      default: span = '{rect_left_r, right_r, rect_top_r, bot_r};
    endcase
  end

  assign line_end   = (along_r == span.along_last);
  assign along_step = pass_r[1] ? along_r - 8'd1 : along_r + 8'd1;
  assign seq_x      = pass_r[0] ? along_r : line_r;
  assign seq_y      = pass_r[0] ? line_r : along_r;
  assign seq_addr   = AW'(seq_y) * AW'(MAX_WIDTH) + AW'(seq_x);

  assign ram_we    = (accept && (in_opcode == OP_WRITE) && on_frame) || (state_r == S_PIX_WR);
  assign ram_waddr = (state_r == S_IDLE) ? in_addr : seq_addr;
  assign ram_wdata = (state_r == S_IDLE) ? in_pixel_in : filt_word;
  assign ram_raddr = (state_r == S_IDLE) ? in_addr : seq_addr;

  assign filt_ctrl.seed       = (state_r == S_SEED);
  assign filt_ctrl.update     = (state_r == S_PIX_WR);
  assign filt_ctrl.alpha_only = alpha_only_r;
  assign filt_ctrl.alpha      = alpha_of_radius(blur_radius_r);

  ebb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ebb_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (filt_ctrl),
    .word_in  (ram_rdata),
    .word_out (filt_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= PASS_DOWN;
      out_valid_r <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_opcode)
              OP_WRITE: begin
                pixel_out_r <= '0;
                op_done_r   <= on_frame;
              end
              OP_READ: begin
                if (on_frame) begin
                  state_r <= S_READ;
                end else begin
                  pixel_out_r <= '0;
                  op_done_r   <= 1'b0;
                end
              end
              OP_RUN: begin
                bot_r   <= bot_clip;
                right_r <= right_clip;
                pass_r  <= PASS_DOWN;
                if (rect_empty) begin
                  pixel_out_r <= '0;
                  op_done_r   <= 1'b1;
                end else begin
                  state_r <= S_PASS;
                end
              end
              default: begin
                pixel_out_r <= '0;
                op_done_r   <= 1'b0;
              end
            endcase
          end
        end
        S_READ: begin
          pixel_out_r <= ram_rdata;
          op_done_r   <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_PASS: begin
          line_r  <= span.line_first;
          along_r <= span.along_first;
          state_r <= S_SEED_RD;
        end
        S_SEED_RD: begin
          state_r <= S_SEED;
        end
        S_SEED, S_PIX_WR: begin
          if (!line_end) begin
            along_r <= along_step;
            state_r <= S_PIX_RD;
          end else if (line_r != span.line_last) begin
            line_r  <= line_r + 8'd1;
            along_r <= span.along_first;
            state_r <= S_SEED_RD;
          end else if (pass_r == PASS_LEFT) begin
            state_r <= S_DONE;
          end else begin
            pass_r  <= pass_r + 2'd1;
            state_r <= S_PASS;
          end
        end
        S_PIX_RD: begin
          state_r <= S_PIX_WR;
        end
        S_DONE: begin
          pixel_out_r <= '0;
          op_done_r   <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = pixel_out_r;
  assign out_op_done   = op_done_r;

endmodule
